/* sv/arcp_pkg.sv */
`default_nettype none
package arcp_pkg;
    localparam int CHANNELS_DEF  = 4;
    localparam int REG_WORDS_DEF = 256;

    localparam logic [3:0] ST_READY = 4'd0;
    localparam logic [3:0] ST_ADDR  = 4'd1;
    localparam logic [3:0] ST_IDCMD = 4'd2;
    localparam logic [3:0] ST_TID   = 4'd3;
    localparam logic [3:0] ST_OP    = 4'd4;
    localparam logic [3:0] ST_OPEX  = 4'd5;
    localparam logic [3:0] ST_DATA  = 4'd6;
    localparam logic [3:0] ST_HEX   = 4'd7;
    localparam logic [3:0] ST_END   = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    localparam logic [3:0] OPC_NONE = 4'd0;
    localparam logic [3:0] OPC_READ = 4'd1;
    localparam logic [3:0] OPC_ADD  = 4'd2;
    localparam logic [3:0] OPC_SUB  = 4'd3;
    localparam logic [3:0] OPC_MUL  = 4'd4;
    localparam logic [3:0] OPC_DIV  = 4'd5;
    localparam logic [3:0] OPC_AND  = 4'd6;
    localparam logic [3:0] OPC_OR   = 4'd7;
    localparam logic [3:0] OPC_XOR  = 4'd8;
    localparam logic [3:0] OPC_BIT  = 4'd9;
    localparam logic [3:0] OPC_EQU  = 4'd10;

    localparam logic [1:0] KIND_ID    = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_REMOTE = 2'd2;

    localparam logic [1:0] CFG_DEVICE_ID = 2'd0;
    localparam logic [1:0] CFG_REPLY_EN  = 2'd1;
    localparam logic [1:0] CFG_MASTER_EN = 2'd2;

    localparam logic [7:0] DEVICE_ID_RST = 8'd1;
endpackage
`default_nettype wire

/* sv/arcp_ram.sv */
`default_nettype none
module arcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/ascii_register_command_parser.sv */
// A byte that does not finish a command passes an accept and a parse cycle; an identity
// or remote result is valid right after the parse cycle.
// A byte that finishes a register command adds a store read, one operation pass and
// a write back; multiply and divide run the operation through a 16-step shift unit.
// A new byte waits until the last one is through and while a finished result is held.
// Reset: synchronous active low; contexts go idle, config to defaults, and a
// clearing pass over all REG_WORDS words zeroes the register store before the first byte.
`default_nettype none
module ascii_register_command_parser #(
    parameter int CHANNELS  = arcp_pkg::CHANNELS_DEF,
    parameter int REG_WORDS = arcp_pkg::REG_WORDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [1:0] channel, [9:2] byte_req, zero fill
    input  wire logic        m_axis_tready,
    output logic             m_axis_tvalid,
    output logic [39:0]      m_axis_tdata,   // out_channel, kind, reg_address, value,
                                             // show_hex, out_of_range, zero fill
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    localparam int AW = (REG_WORDS > 1) ? $clog2(REG_WORDS) : 1;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_PARSE, S_READ, S_EXEC, S_ITER, S_WRITE
    } t_state;

    t_state r_state;

    // per-channel contexts
    logic [3:0]  r_pst   [CHANNELS];
    logic [15:0] r_addr  [CHANNELS];
    logic [15:0] r_data  [CHANNELS];
    logic [7:0]  r_tid   [CHANNELS];
    logic [7:0]  r_bidx  [CHANNELS];
    logic [3:0]  r_op    [CHANNELS];
    logic [2:0]  r_flags [CHANNELS];

    logic [7:0]  r_dev_id;
    logic        r_reply_en, r_master_en;

    logic [1:0]  r_chan;
    logic [7:0]  r_byte;
    logic [AW:0] r_clr;
    logic [15:0] r_acc, r_opnd, r_rem;
    logic [4:0]  r_cnt;
    logic        r_oor;
    logic [15:0] r_caddr;
    logic        r_hex;
    logic [3:0]  r_cop;
    logic [3:0]  r_cbit;

    logic        r_ovalid;
    logic [39:0] r_odata;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata, ram_rdata;
    logic [15:0]   res_val;

    arcp_ram #(.WIDTH(16), .DEPTH(REG_WORDS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_caddr[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    // take a byte only when the output register is free or drains this cycle
    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // final value: product, all-ones divide-by-zero result, or r_acc (quotient or other op)
    assign res_val = (r_cop == arcp_pkg::OPC_MUL) ? r_rem
                   : (r_cop == arcp_pkg::OPC_DIV && r_opnd == 16'd0) ? 16'hFFFF
                   : r_acc;

    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_WRITE && !r_oor);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr[AW-1:0] : r_caddr[AW-1:0];
    assign ram_wdata = (r_state == S_CLEAR) ? 16'd0 : res_val;

    // combinational parse of the held byte against its channel context
    logic [3:0]  p_pst;
    logic [15:0] p_addr, p_data;
    logic [7:0]  p_tid, p_bidx;
    logic [3:0]  p_op;
    logic [2:0]  p_flags;
    logic        dec, hexd;
    logic [3:0]  dig, hdig;
    logic [CW-1:0] ci;

    always_comb begin
        ci   = r_chan[CW-1:0];
        dec  = (r_byte >= "0") && (r_byte <= "9");
        dig  = 4'(r_byte - "0");
        hexd = 1'b1;
        if (dec) hdig = dig;
        else if (r_byte >= "a" && r_byte <= "f") hdig = 4'(r_byte - "a" + 8'd10);
        else if (r_byte >= "A" && r_byte <= "F") hdig = 4'(r_byte - "A" + 8'd10);
        else begin
            hdig = 4'd0;
            hexd = 1'b0;
        end
        p_pst = r_pst[ci]; p_addr = r_addr[ci]; p_data = r_data[ci];
        p_tid = r_tid[ci]; p_bidx = r_bidx[ci]; p_op = r_op[ci]; p_flags = r_flags[ci];
        case (r_pst[ci])
            arcp_pkg::ST_ADDR: begin
                if (dec) p_addr = 16'((p_addr << 3) + (p_addr << 1) + 16'(dig));
                else if (r_byte == "@") p_pst = arcp_pkg::ST_TID;
                else if (r_byte == "]" || r_byte == ")") p_pst = arcp_pkg::ST_OP;
                else if (r_byte == "i" || r_byte == "I") p_pst = arcp_pkg::ST_IDCMD;
                else p_pst = arcp_pkg::ST_READY;
            end
            arcp_pkg::ST_IDCMD: begin
                if (r_byte == "d" || r_byte == "D") p_flags[2] = 1'b1;
                else if (r_byte == "]") p_pst = arcp_pkg::ST_OP;
                else p_pst = arcp_pkg::ST_READY;
            end
            arcp_pkg::ST_TID: begin
                if (dec) p_tid = 8'((p_tid << 3) + (p_tid << 1) + 8'(dig));
                else if (r_byte == "]") p_pst = arcp_pkg::ST_OP;
                else p_pst = arcp_pkg::ST_READY;
            end
            arcp_pkg::ST_OP: begin
                p_pst = arcp_pkg::ST_OPEX;
                case (r_byte)
                    "+": p_op = arcp_pkg::OPC_ADD;
                    "-": p_op = arcp_pkg::OPC_SUB;
                    "*": p_op = arcp_pkg::OPC_MUL;
                    "/": p_op = arcp_pkg::OPC_DIV;
                    "&": p_op = arcp_pkg::OPC_AND;
                    "|": p_op = arcp_pkg::OPC_OR;
                    "^": p_op = arcp_pkg::OPC_XOR;
                    ".": p_op = arcp_pkg::OPC_BIT;
                    "=": begin
                        p_op = arcp_pkg::OPC_EQU;
                        p_pst = arcp_pkg::ST_DATA;
                    end
                    "?": begin
                        p_op = arcp_pkg::OPC_READ;
                        p_pst = arcp_pkg::ST_END;
                    end
                    "x": begin
                        p_flags[1] = 1'b1;
                        p_pst = arcp_pkg::ST_OP;
                    end
                    default: p_pst = arcp_pkg::ST_READY;
                endcase
            end
            arcp_pkg::ST_OPEX: begin
                if (dec) p_bidx = 8'((p_bidx << 3) + (p_bidx << 1) + 8'(dig));
                else if (r_byte == "=") begin
                    p_bidx = p_bidx & 8'h0F;
                    p_pst = arcp_pkg::ST_DATA;
                end else p_pst = arcp_pkg::ST_READY;
            end
            arcp_pkg::ST_DATA: begin
                if (dec) p_data = 16'((p_data << 3) + (p_data << 1) + 16'(dig));
                else if (r_byte == ";") p_pst = arcp_pkg::ST_DONE;
                else if (r_byte == "x" || r_byte == "X") begin
                    p_data = 16'd0;
                    p_flags[1] = 1'b1;
                    p_pst = arcp_pkg::ST_HEX;
                end else p_pst = arcp_pkg::ST_READY;
            end
            arcp_pkg::ST_HEX: begin
                if (hexd) p_data = {p_data[11:0], hdig};
                else if (r_byte == ";") p_pst = arcp_pkg::ST_DONE;
                else p_pst = arcp_pkg::ST_READY;
            end
            arcp_pkg::ST_END: begin
                if (r_byte == ";") p_pst = arcp_pkg::ST_DONE;
            end
            default: ;
        endcase
    end

    logic        tid_ok;
    logic [15:0] bit_mask;
    logic [16:0] div_try;
    assign tid_ok   = (p_tid == 8'd0) || (p_tid == r_dev_id);
    assign bit_mask = 16'd1 << r_cbit;
    assign div_try  = {r_rem, r_acc[15]} - {1'b0, r_opnd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ovalid    <= 1'b0;
            r_dev_id    <= arcp_pkg::DEVICE_ID_RST;
            r_reply_en  <= 1'b1;
            r_master_en <= 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
                r_pst[c] <= arcp_pkg::ST_READY;
                r_addr[c] <= '0; r_data[c] <= '0; r_tid[c] <= '0;
                r_bidx[c] <= '0; r_op[c] <= arcp_pkg::OPC_NONE; r_flags[c] <= '0;
            end
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            // config writes land at any time
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    arcp_pkg::CFG_DEVICE_ID: r_dev_id <= i_cfg_data;
                    arcp_pkg::CFG_REPLY_EN:  r_reply_en <= i_cfg_data[0];
                    arcp_pkg::CFG_MASTER_EN: r_master_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(REG_WORDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    // hold off while a finished result still waits
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_chan <= s_axis_tdata[1:0];
                        r_byte <= s_axis_tdata[9:2];
                        r_state <= (32'(s_axis_tdata[1:0]) < CHANNELS) ? S_PARSE : S_IDLE;
                    end
                end
                S_PARSE: begin
                    r_state <= S_IDLE;
                    r_pst[ci] <= p_pst; r_addr[ci] <= p_addr; r_data[ci] <= p_data;
                    r_tid[ci] <= p_tid; r_bidx[ci] <= p_bidx; r_op[ci] <= p_op;
                    r_flags[ci] <= p_flags;
                    r_caddr <= p_addr;
                    r_opnd  <= p_data;
                    r_hex   <= p_flags[1];
                    r_cop   <= p_op;
                    r_cbit  <= p_bidx[3:0];
                    r_oor   <= 32'(p_addr) >= REG_WORDS;
                    r_odata <= '0;
                    r_odata[1:0] <= r_chan;
                    if (p_pst == arcp_pkg::ST_DONE) begin
                        r_pst[ci] <= arcp_pkg::ST_READY;
                        if (p_flags[2]) begin
                            if (r_reply_en) begin
                                r_odata[3:2] <= arcp_pkg::KIND_ID;
                                r_odata[35:20] <= {8'd0, r_dev_id};
                                r_ovalid <= 1'b1;
                            end
                        end else if (tid_ok) begin
                            if (!p_flags[0]) begin
                                if (r_master_en) begin
                                    r_odata[3:2] <= arcp_pkg::KIND_REMOTE;
                                    r_odata[19:4] <= p_addr;
                                    r_odata[35:20] <= p_data;
                                    r_odata[36] <= p_flags[1];
                                    r_ovalid <= 1'b1;
                                end
                            end else r_state <= S_READ;
                        end
                    end
                    // frame start restarts the context after the byte
                    if (r_byte == "[" || r_byte == "(") begin
                        r_pst[ci] <= arcp_pkg::ST_ADDR;
                        r_addr[ci] <= '0; r_data[ci] <= '0; r_tid[ci] <= '0;
                        r_bidx[ci] <= '0; r_op[ci] <= arcp_pkg::OPC_NONE;
                        r_flags[ci] <= {2'b00, r_byte == "["};
                    end
                end
                S_READ: r_state <= S_EXEC;
                S_EXEC: begin
                    r_cnt <= 5'd0;
                    r_rem <= '0;
                    r_state <= S_WRITE;
                    case (r_cop)
                        arcp_pkg::OPC_ADD: r_acc <= (r_oor ? 16'd0 : ram_rdata) + r_opnd;
                        arcp_pkg::OPC_SUB: r_acc <= (r_oor ? 16'd0 : ram_rdata) - r_opnd;
                        arcp_pkg::OPC_AND: r_acc <= (r_oor ? 16'd0 : ram_rdata) & r_opnd;
                        arcp_pkg::OPC_OR:  r_acc <= (r_oor ? 16'd0 : ram_rdata) | r_opnd;
                        arcp_pkg::OPC_XOR: r_acc <= (r_oor ? 16'd0 : ram_rdata) ^ r_opnd;
                        arcp_pkg::OPC_EQU: r_acc <= r_opnd;
                        arcp_pkg::OPC_BIT: r_acc <= (r_opnd != 16'd0)
                            ? ((r_oor ? 16'd0 : ram_rdata) | bit_mask)
                            : ((r_oor ? 16'd0 : ram_rdata) & ~bit_mask);
                        arcp_pkg::OPC_MUL, arcp_pkg::OPC_DIV: begin
                            r_acc <= r_oor ? 16'd0 : ram_rdata;
                            r_state <= S_ITER;
                        end
                        default: r_acc <= r_oor ? 16'd0 : ram_rdata;
                    endcase
                end
                S_ITER: begin
                    // one shift-add or shift-subtract step per cycle
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cop == arcp_pkg::OPC_MUL) begin
                        // r_rem holds the product, r_acc the multiplicand, shifted into place per step
                        if (r_opnd[r_cnt[3:0]]) r_rem <= r_rem + (r_acc << r_cnt[3:0]);
                    end else begin
                        r_rem <= div_try[16] ? {r_rem[14:0], r_acc[15]} : div_try[15:0];
                        r_acc <= {r_acc[14:0], ~div_try[16]};
                    end
                    if (r_cnt == 5'd15) r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                    if (r_reply_en) begin
                        r_odata[3:2] <= arcp_pkg::KIND_WRITE;
                        r_odata[19:4] <= r_caddr;
                        r_odata[35:20] <= res_val;
                        r_odata[36] <= r_hex;
                        r_odata[37] <= r_oor;
                        r_ovalid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
